// ===== sv/lsst_pkg.sv =====
// types, constants and control store of the light-seeking servo tracker
package lsst_pkg;

   // fixed field widths
   localparam int ANGLE_W = 8;
   localparam int LEVEL_W = 10;
   localparam int STEP_W  = 7;
   localparam int AVG_W   = 7;
   localparam int SUM_W   = 16;
   localparam int REM_W   = 7;
   localparam int DCNT_W  = 4;

   // defaults and reset values of the registers
   localparam int                 MAX_ANGLE_DEFAULT = 180;
   localparam logic [STEP_W-1:0]  STEP_RESET        = 7'd5;
   localparam logic [AVG_W-1:0]   AVG_RESET         = 7'd50;
   localparam logic [ANGLE_W-1:0] HOME_RESET        = 8'd90;
   localparam logic [AVG_W-1:0]   AVG_LIMIT         = 7'd64;
   localparam logic [DCNT_W-1:0]  DIV_LAST          = 4'd15;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_STEP_SIZE  = 2'd0,
      CSR_AVG_COUNT  = 2'd1,
      CSR_HOME_ANGLE = 2'd2
   } csr_index_type;

   // tracking phase
   typedef enum logic [1:0] {
      PH_CENTRE = 2'd0,
      PH_PLUS   = 2'd1,
      PH_MINUS  = 2'd2,
      PH_SWEEP  = 2'd3
   } phase_type;

   // datapath action of one microstep
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_LATCH    = 3'd1,
      ACT_ACCUM    = 3'd2,
      ACT_DIV_LOAD = 3'd3,
      ACT_DIV_STEP = 3'd4,
      ACT_DECIDE   = 3'd5,
      ACT_SCAN     = 3'd6
   } act_type;

   // jump condition of one microstep
   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_BEAT  = 3'd2,
      COND_CMD      = 3'd3,
      COND_NOT_FULL = 3'd4,
      COND_DIV_MORE = 3'd5,
      COND_SWEEP    = 3'd6
   } cond_type;

   typedef logic [2:0] upc_type;

   // microprogram addresses
   localparam upc_type UPC_WAIT     = 3'd0;
   localparam upc_type UPC_DISPATCH = 3'd1;
   localparam upc_type UPC_ACCUM    = 3'd2;
   localparam upc_type UPC_DIV_LOAD = 3'd3;
   localparam upc_type UPC_DIV_STEP = 3'd4;
   localparam upc_type UPC_DECIDE   = 3'd5;
   localparam upc_type UPC_SCAN_CHK = 3'd6;
   localparam upc_type UPC_SCAN     = 3'd7;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   // control store: one word per microstep
   function automatic ctrl_word_type micro_rom(input upc_type upc);
      ctrl_word_type cw;
      unique case (upc)
         UPC_WAIT:     cw = '{ACT_LATCH,    COND_NO_BEAT,  UPC_WAIT};
         UPC_DISPATCH: cw = '{ACT_NONE,     COND_CMD,      UPC_SCAN_CHK};
         UPC_ACCUM:    cw = '{ACT_ACCUM,    COND_NOT_FULL, UPC_WAIT};
         UPC_DIV_LOAD: cw = '{ACT_DIV_LOAD, COND_NEXT,     UPC_WAIT};
         UPC_DIV_STEP: cw = '{ACT_DIV_STEP, COND_DIV_MORE, UPC_DIV_STEP};
         UPC_DECIDE:   cw = '{ACT_DECIDE,   COND_ALWAYS,   UPC_WAIT};
         UPC_SCAN_CHK: cw = '{ACT_NONE,     COND_SWEEP,    UPC_WAIT};
         UPC_SCAN:     cw = '{ACT_SCAN,     COND_ALWAYS,   UPC_WAIT};
         default:      cw = '{ACT_NONE,     COND_ALWAYS,   UPC_WAIT};
      endcase
      return cw;
   endfunction

endpackage

// ===== sv/light_seeking_servo_tracker.sv =====
// light-seeking servo tracker: microcoded perturb-and-observe controller
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata: light_sample; tuser: command
//   rsp      out  rsp_tvalid/tready    tdata: servo_angle, measured_level; tuser: scanning
//   csr      in   csr_we               csr_addr, csr_wdata
//
// a sample runs wait, dispatch, accumulate, one completing the average also divide load,
// a 16-step restoring divider (one quotient bit a cycle) and decide; a scan request runs
// wait, dispatch, scan check, scan; synchronous active-high reset returns the registers
// to their defaults, the servo to the home angle and the sequencer to the wait step
// a result waits in the output register; the next beat is taken meanwhile and the
// sequencer stalls only when it has a new result and the old one is still held
module light_seeking_servo_tracker
   import lsst_pkg::*;
#(
   parameter int MAX_ANGLE = MAX_ANGLE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] light_sample, rest zero
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] servo_angle, [17:8] measured_level, rest zero
   output logic        rsp_tuser,   // [0] scanning
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   localparam logic [ANGLE_W-1:0] MAX_A     = ANGLE_W'(MAX_ANGLE);
   localparam logic [ANGLE_W-1:0] CUR_RESET = (HOME_RESET > MAX_A) ? MAX_A : HOME_RESET;

   // sequencer
   upc_type       upc_ff, upc_in;
   ctrl_word_type cw;
   logic          cond_hit;
   logic          emit;
   logic          stall;

   // latched beat
   logic               cmd_ff, cmd_in;
   logic [LEVEL_W-1:0] smp_ff, smp_in;

   // configuration
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;

   // tracking state
   phase_type          phase_ff, phase_in;
   logic [ANGLE_W-1:0] cur_ff, cur_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [AVG_W-1:0]   cnt_ff, cnt_in;
   logic [LEVEL_W-1:0] centre_ff, centre_in;
   logic [LEVEL_W-1:0] plus_ff, plus_in;
   logic [LEVEL_W-1:0] best_lvl_ff, best_lvl_in;
   logic [ANGLE_W-1:0] best_ang_ff, best_ang_in;
   logic [ANGLE_W-1:0] sweep_ff, sweep_in;

   // divider
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quot_ff, quot_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_scan_ff, rsp_scan_in;

   // shared datapath terms
   logic [AVG_W-1:0]   n_eff;
   logic               not_full;
   logic [AVG_W:0]     div_part;
   logic               div_ge;
   logic [AVG_W:0]     div_diff;
   logic [LEVEL_W-1:0] level;
   logic [ANGLE_W:0]   plus_sum;
   logic               plus_ok;
   logic               minus_ok;
   logic [ANGLE_W-1:0] cur_p;
   logic [ANGLE_W-1:0] cur_m;
   logic               req_beat;

   // effective average count, held in 1..64
   always_comb begin
      if (avg_ff == '0) begin
         n_eff = AVG_W'(1);
      end else if (avg_ff > AVG_LIMIT) begin
         n_eff = AVG_LIMIT;
      end else begin
         n_eff = avg_ff;
      end
   end

   assign req_beat = req_tvalid && req_tready;
   assign not_full = ({1'b0, cnt_ff} + (AVG_W+1)'(1)) < {1'b0, n_eff};

   // one restoring division step
   assign div_part = {rem_ff, quot_ff[SUM_W-1]};
   assign div_ge   = div_part >= {1'b0, n_eff};
   assign div_diff = div_part - {1'b0, n_eff};
   assign level    = quot_ff[LEVEL_W-1:0];

   // probe positions
   assign plus_sum = {1'b0, cur_ff} + {2'b0, step_ff};
   assign plus_ok  = plus_sum <= {1'b0, MAX_A};
   assign minus_ok = cur_ff >= {1'b0, step_ff};
   assign cur_p    = plus_sum[ANGLE_W-1:0];
   assign cur_m    = cur_ff - {1'b0, step_ff};

   // control word fetch, jump condition and next step
   always_comb begin
      cw    = micro_rom(upc_ff);
      emit  = (cw.act == ACT_DECIDE) || (cw.act == ACT_SCAN);
      stall = emit && rsp_valid_ff && !rsp_tready;
      case (cw.cond)
         COND_NEXT:     cond_hit = 1'b0;
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_NO_BEAT:  cond_hit = !req_beat;
         COND_CMD:      cond_hit = cmd_ff;
         COND_NOT_FULL: cond_hit = not_full;
         COND_DIV_MORE: cond_hit = dcnt_ff != DIV_LAST;
         COND_SWEEP:    cond_hit = phase_ff == PH_SWEEP;
         default:       cond_hit = 1'b1;
      endcase
      if (stall) begin
         upc_in = upc_ff;
      end else if (cond_hit) begin
         upc_in = cw.target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   assign req_tready = cw.act == ACT_LATCH;

   // datapath actions
   always_comb begin
      cmd_in       = cmd_ff;
      smp_in       = smp_ff;
      step_in      = step_ff;
      avg_in       = avg_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      centre_in    = centre_ff;
      plus_in      = plus_ff;
      best_lvl_in  = best_lvl_ff;
      best_ang_in  = best_ang_ff;
      sweep_in     = sweep_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      dcnt_in      = dcnt_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_level_in = rsp_level_ff;
      rsp_scan_in  = rsp_scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (cw.act)
         // capture the beat
         ACT_LATCH: begin
            if (req_beat) begin
               cmd_in = req_tuser;
               smp_in = req_tdata[LEVEL_W-1:0];
            end
         end
         // add the sample to the running sum
         ACT_ACCUM: begin
            sum_in = sum_ff + {{(SUM_W-LEVEL_W){1'b0}}, smp_ff};
            cnt_in = cnt_ff + AVG_W'(1);
         end
         // start the divide with the completed sum, last sample already added
         ACT_DIV_LOAD: begin
            rem_in  = '0;
            quot_in = sum_ff;
            dcnt_in = '0;
            sum_in  = '0;
            cnt_in  = '0;
         end
         ACT_DIV_STEP: begin
            rem_in  = div_ge ? div_diff[REM_W-1:0] : div_part[REM_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], div_ge};
            dcnt_in = dcnt_ff + DCNT_W'(1);
         end
         // act on the new average
         ACT_DECIDE: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level;
               rsp_scan_in  = 1'b0;
               unique case (phase_ff)
                  PH_SWEEP: begin
                     if (level > best_lvl_ff) begin
                        best_lvl_in = level;
                        best_ang_in = sweep_ff;
                     end
                     if (sweep_ff >= MAX_A) begin
                        cur_in       = (level > best_lvl_ff) ? sweep_ff : best_ang_ff;
                        phase_in     = PH_CENTRE;
                        rsp_angle_in = cur_in;
                     end else begin
                        sweep_in     = sweep_ff + ANGLE_W'(1);
                        rsp_angle_in = sweep_in;
                        rsp_scan_in  = 1'b1;
                     end
                  end
                  PH_PLUS: begin
                     plus_in = level;
                     if (minus_ok) begin
                        phase_in     = PH_MINUS;
                        rsp_angle_in = cur_m;
                     end else begin
                        if (level > centre_ff) begin
                           cur_in = cur_p;
                        end
                        phase_in     = PH_CENTRE;
                        rsp_angle_in = cur_in;
                     end
                  end
                  PH_MINUS: begin
                     // both probes: strictly brighter plus wins, a tie above the centre goes minus
                     if (plus_ok) begin
                        if (plus_ff > centre_ff && plus_ff > level) begin
                           cur_in = cur_p;
                        end else if (level > centre_ff && level >= plus_ff) begin
                           cur_in = cur_m;
                        end
                     end else if (level > centre_ff) begin
                        cur_in = cur_m;
                     end
                     phase_in     = PH_CENTRE;
                     rsp_angle_in = cur_in;
                  end
                  PH_CENTRE: begin
                     centre_in = level;
                     if (plus_ok) begin
                        phase_in     = PH_PLUS;
                        rsp_angle_in = cur_p;
                     end else if (minus_ok) begin
                        phase_in     = PH_MINUS;
                        rsp_angle_in = cur_m;
                     end else begin
                        phase_in     = PH_CENTRE;
                        rsp_angle_in = cur_ff;
                     end
                  end
                  default: begin
                     phase_in = PH_CENTRE;
                  end
               endcase
            end
         end
         // start a full sweep
         ACT_SCAN: begin
            if (!stall) begin
               phase_in     = PH_SWEEP;
               sum_in       = '0;
               cnt_in       = '0;
               sweep_in     = '0;
               best_lvl_in  = '0;
               best_ang_in  = '0;
               rsp_valid_in = 1'b1;
               rsp_angle_in = '0;
               rsp_level_in = '0;
               rsp_scan_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // register writes
      if (csr_we) begin
         case (csr_addr)
            CSR_STEP_SIZE:  step_in = csr_wdata[STEP_W-1:0];
            CSR_AVG_COUNT:  avg_in  = csr_wdata[AVG_W-1:0];
            CSR_HOME_ANGLE: begin
               cur_in   = (csr_wdata > MAX_A) ? MAX_A : csr_wdata;
               phase_in = PH_CENTRE;
               sum_in   = '0;
               cnt_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_WAIT;
         step_ff      <= STEP_RESET;
         avg_ff       <= AVG_RESET;
         phase_ff     <= PH_CENTRE;
         cur_ff       <= CUR_RESET;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         centre_ff    <= '0;
         plus_ff      <= '0;
         best_lvl_ff  <= '0;
         best_ang_ff  <= '0;
         sweep_ff     <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         step_ff      <= step_in;
         avg_ff       <= avg_in;
         phase_ff     <= phase_in;
         cur_ff       <= cur_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         centre_ff    <= centre_in;
         plus_ff      <= plus_in;
         best_lvl_ff  <= best_lvl_in;
         best_ang_ff  <= best_ang_in;
         sweep_ff     <= sweep_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      smp_ff       <= smp_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_level_ff <= rsp_level_in;
      rsp_scan_ff  <= rsp_scan_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_level_ff, rsp_angle_ff};
   assign rsp_tuser  = rsp_scan_ff;

   // servo command never leaves the mechanical range
   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= MAX_A && sweep_ff <= MAX_A)
      else $error("servo or sweep angle beyond range");

   // a new result is only loaded into a free or draining output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit && !stall) |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   // the divider runs exactly sixteen steps before the decision
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_DIV_STEP && dcnt_ff == DIV_LAST) |=> upc_ff == UPC_DECIDE)
      else $error("divider did not finish after its last step");

   // no beat is taken outside the wait step
   a_beat_wait: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> ($past(upc_ff) == UPC_WAIT) && (upc_ff == UPC_DISPATCH))
      else $error("beat taken outside wait step");

endmodule

// ===== bench/light_tracker_checker.sv =====
// result checker for the light-seeking servo tracker: tracks state and compares result beats
`timescale 1ns / 1ps
module light_tracker_checker
   import lsst_pkg::*;
#(
   parameter int MAX_ANGLE = MAX_ANGLE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] light_sample, rest zero
   input  logic        req_tuser,   // [0] command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [7:0] servo_angle, [17:8] measured_level, rest zero
   input  logic        rsp_tuser,   // [0] scanning
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [LEVEL_W-1:0] level;
      logic               scanning;
   } servo_move_type;

   servo_move_type servo_moves_due[$];

   // register copies
   logic [STEP_W-1:0]  step_size;
   logic [AVG_W-1:0]   avg_count;
   logic [ANGLE_W-1:0] home_angle;

   // tracker state
   phase_type          track_phase;
   logic [ANGLE_W-1:0] cur_angle;
   logic [SUM_W-1:0]   acc_sum;
   logic [AVG_W-1:0]   acc_count;
   logic [LEVEL_W-1:0] centre_lvl;
   logic [LEVEL_W-1:0] plus_lvl;
   logic [LEVEL_W-1:0] best_lvl;
   logic [ANGLE_W-1:0] best_ang;
   logic [ANGLE_W-1:0] sweep_ang;

   function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
      return (int'(a) > MAX_ANGLE) ? ANGLE_W'(MAX_ANGLE) : a;
   endfunction

   function automatic logic plus_fits();
      return int'(cur_angle) + int'(step_size) <= MAX_ANGLE;
   endfunction

   function automatic logic minus_fits();
      return int'(cur_angle) >= int'(step_size);
   endfunction

   task automatic restart_local();
      track_phase = PH_CENTRE;
      acc_sum     = '0;
      acc_count   = '0;
   endtask

   // works out the result, if any, that one request beat causes
   task automatic predict_servo_move(input logic cmd, input logic [LEVEL_W-1:0] sample);
      int             n;
      logic           had_plus;
      servo_move_type mv;
      mv = '0;
      if (cmd) begin
         // scan request: ignored while a sweep runs
         if (track_phase == PH_SWEEP) return;
         track_phase = PH_SWEEP;
         acc_sum     = '0;
         acc_count   = '0;
         sweep_ang   = '0;
         best_lvl    = '0;
         best_ang    = '0;
         mv.scanning = 1'b1;
         servo_moves_due.push_back(mv);
         return;
      end
      // zero acts as one, above the limit acts as the limit
      n = int'(avg_count);
      if (n == 0) n = 1;
      if (n > int'(AVG_LIMIT)) n = int'(AVG_LIMIT);
      acc_sum   = acc_sum + SUM_W'(sample);
      acc_count = acc_count + 1'b1;
      if (int'(acc_count) < n) return;
      mv.level  = LEVEL_W'(int'(acc_sum) / n);
      acc_sum   = '0;
      acc_count = '0;
      case (track_phase)
         PH_SWEEP: begin
            if (mv.level > best_lvl) begin
               best_lvl = mv.level;
               best_ang = sweep_ang;
            end
            if (int'(sweep_ang) >= MAX_ANGLE) begin
               cur_angle   = best_ang;
               track_phase = PH_CENTRE;
               mv.angle    = cur_angle;
            end else begin
               sweep_ang   = sweep_ang + 1'b1;
               mv.angle    = sweep_ang;
               mv.scanning = 1'b1;
            end
         end
         PH_PLUS: begin
            plus_lvl = mv.level;
            if (minus_fits()) begin
               track_phase = PH_MINUS;
               mv.angle    = cur_angle - step_size;
            end else begin
               if (plus_lvl > centre_lvl) cur_angle = cur_angle + step_size;
               track_phase = PH_CENTRE;
               mv.angle    = cur_angle;
            end
         end
         PH_MINUS: begin
            had_plus = plus_fits();
            if (had_plus) begin
               // strictly brighter plus wins, a tie above the centre goes minus
               if (plus_lvl > centre_lvl && plus_lvl > mv.level)
                  cur_angle = cur_angle + step_size;
               else if (mv.level > centre_lvl && mv.level >= plus_lvl)
                  cur_angle = cur_angle - step_size;
            end else if (mv.level > centre_lvl) begin
               cur_angle = cur_angle - step_size;
            end
            track_phase = PH_CENTRE;
            mv.angle    = cur_angle;
         end
         default: begin
            centre_lvl = mv.level;
            if (plus_fits()) begin
               track_phase = PH_PLUS;
               mv.angle    = cur_angle + step_size;
            end else if (minus_fits()) begin
               track_phase = PH_MINUS;
               mv.angle    = cur_angle - step_size;
            end else begin
               track_phase = PH_CENTRE;
               mv.angle    = cur_angle;
            end
         end
      endcase
      servo_moves_due.push_back(mv);
   endtask

   // watch all three ports on each rising edge
   always @(posedge clock) begin
      servo_move_type want;
      if (reset) begin
         step_size  = STEP_RESET;
         avg_count  = AVG_RESET;
         home_angle = HOME_RESET;
         cur_angle  = clamp_angle(home_angle);
         centre_lvl = '0;
         plus_lvl   = '0;
         best_lvl   = '0;
         best_ang   = '0;
         sweep_ang  = '0;
         restart_local();
         servo_moves_due.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_addr == CSR_STEP_SIZE) begin
               step_size = csr_wdata[STEP_W-1:0];
            end else if (csr_addr == CSR_AVG_COUNT) begin
               avg_count = csr_wdata[AVG_W-1:0];
            end else if (csr_addr == CSR_HOME_ANGLE) begin
               home_angle = csr_wdata;
               cur_angle  = clamp_angle(home_angle);
               restart_local();
            end
         end
         // result beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (servo_moves_due.size() == 0) begin
               $error("result beat with nothing expected: angle %0d level %0d scanning %0b",
                      rsp_tdata[7:0], rsp_tdata[17:8], rsp_tuser);
               fail_count++;
            end else begin
               want = servo_moves_due.pop_front();
               if (rsp_tdata[7:0] !== want.angle) begin
                  $error("servo_angle: expected %0d, got %0d", want.angle, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[17:8] !== want.level) begin
                  $error("measured_level: expected %0d, got %0d", want.level, rsp_tdata[17:8]);
                  fail_count++;
               end
               if (rsp_tuser !== want.scanning) begin
                  $error("scanning: expected %0b, got %0b", want.scanning, rsp_tuser);
                  fail_count++;
               end
            end
         end
         // request beat
         if (req_tvalid && req_tready) predict_servo_move(req_tuser, req_tdata[LEVEL_W-1:0]);
      end
      pending = servo_moves_due.size();
   end

endmodule

// ===== bench/tb_light_seeking_servo_tracker.sv =====
// bench top for the light-seeking servo tracker: clock, reset, stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_light_seeking_servo_tracker
   import lsst_pkg::*;
();

   localparam int ITEM_TARGET   = 650;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // [9:0] light_sample, rest zero
   logic        req_tuser  = 1'b0;  // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] servo_angle, [17:8] measured_level, rest zero
   logic        rsp_tuser;          // [0] scanning
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = CSR_STEP_SIZE;
   logic [7:0]  csr_wdata  = '0;
   int          fail_count;
   int          pending;

   int req_idle_pct  = 20;
   int rsp_stall_pct = 20;
   int stall_left    = 0;
   int quiet_cycles  = 0;
   int beats_sent    = 0;

   light_seeking_servo_tracker dut (.*);

   light_tracker_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // idle length: mostly short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) stall_left = pick_gap();
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // one request beat, with an optional gap before it
   task automatic send_beat(input logic cmd, input logic [9:0] sample);
      int gap;
      gap = ($urandom_range(0, 99) < req_idle_pct) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // drop valid, drain all results, let a final divide finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // home angle last, since it restarts local tracking
   task automatic write_regs(input logic [6:0] step, input logic [6:0] avg,
                             input logic [7:0] home);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_STEP_SIZE;
      csr_wdata <= {1'b0, step};
      @(negedge clock);
      csr_addr  <= CSR_AVG_COUNT;
      csr_wdata <= {1'b0, avg};
      @(negedge clock);
      csr_addr  <= CSR_HOME_ANGLE;
      csr_wdata <= home;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int         p, step, avg, home, items, mode, peak, slope, apart, lvl;
      logic [9:0] mask;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // low edge, one-degree step, zero average count acting as one
      write_regs(7'd1, 7'd0, 8'd0);
      send_beat(1'b0, 10'd0);
      send_beat(1'b0, 10'd1023);
      send_beat(1'b0, 10'd1023);
      send_beat(1'b0, 10'd0);
      send_beat(1'b0, 10'd0);
      settle();

      // home above range saturates, then a probe tie above the centre
      write_regs(7'd5, 7'd1, 8'd255);
      send_beat(1'b0, 10'd100);
      send_beat(1'b0, 10'd200);
      send_beat(1'b0, 10'd10);
      send_beat(1'b0, 10'd500);
      send_beat(1'b0, 10'd500);
      settle();

      // no probe fits, scan request, repeated request ignored, sweep aborted later
      write_regs(7'd127, 7'd1, 8'd90);
      send_beat(1'b0, 10'd300);
      send_beat(1'b1, 10'd0);
      send_beat(1'b1, 10'h3FF);
      beats_sent--;
      send_beat(1'b0, 10'd5);
      settle();

      // widest step reaching both ends, two-sample average
      write_regs(7'd90, 7'd2, 8'd90);
      send_beat(1'b0, 10'd1023);
      send_beat(1'b0, 10'd1023);
      send_beat(1'b0, 10'd0);
      send_beat(1'b0, 10'd0);
      send_beat(1'b0, 10'd1023);
      send_beat(1'b0, 10'd1023);
      settle();

      // random phases, each with its own register setting
      for (p = 0; beats_sent < ITEM_TARGET; p++) begin
         req_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : 30;
         rsp_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         if (p == 1 || p == 4) begin
            // full sweep over a light profile, flat or coarse profiles give ties
            write_regs(7'($urandom_range(1, 90)), 7'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
            peak  = $urandom_range(0, MAX_ANGLE_DEFAULT);
            slope = $urandom_range(0, 8);
            mask  = ($urandom_range(0, 1) == 0) ? 10'h3FF : 10'h3E0;
            send_beat(1'b1, 10'($urandom));
            for (int a = 0; a <= MAX_ANGLE_DEFAULT; a++) begin
               if (a == 90) begin
                  // request during the sweep does nothing
                  send_beat(1'b1, 10'($urandom));
                  beats_sent--;
               end
               apart = (a > peak) ? a - peak : peak - a;
               lvl   = 1023 - apart * slope;
               if (lvl < 0) lvl = 0;
               send_beat(1'b0, 10'(lvl) & mask);
            end
            repeat (20) send_beat(1'b0, 10'($urandom));
         end else begin
            if (p == 2) begin
               // longest average, above the limit or at it
               step  = $urandom_range(1, 90);
               avg   = ($urandom_range(0, 1) == 0) ? 64 : 127;
               items = 140;
            end else begin
               avg = $urandom_range(1, 4);
               case ($urandom_range(0, 9))
                  0:       step = $urandom_range(91, 127);
                  1:       step = 0;
                  2:       step = $urandom_range(21, 90);
                  default: step = $urandom_range(1, 20);
               endcase
               items = $urandom_range(30, 70);
            end
            case ($urandom_range(0, 4))
               0:       home = 0;
               1:       home = MAX_ANGLE_DEFAULT;
               default: home = $urandom_range(0, 255);
            endcase
            mode = $urandom_range(0, 2);
            write_regs(7'(step), 7'(avg), 8'(home));
            repeat (items) begin
               if ($urandom_range(0, 59) == 0) begin
                  send_beat(1'b1, 10'($urandom));
               end else begin
                  case (mode)
                     0:       send_beat(1'b0, 10'($urandom));
                     1:       send_beat(1'b0, 10'($urandom_range(0, 3)));
                     default: send_beat(1'b0, 10'($urandom_range(500, 520)));
                  endcase
               end
            end
         end
         settle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (pending != 0) $error("%0d expected results never arrived", pending);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
